// ===== hw/rtl/cbc_pkg.sv =====
// Shared types, codes and helpers for the cartridge bank controller.
`timescale 1ns / 1ps

package cbc_pkg;

	localparam int ROM_BANK_BITS  = 9;
	localparam int RAM_BANK_BYTES = 8192;
	localparam int RAM_OFS_BITS   = $clog2(RAM_BANK_BYTES);
	localparam int RAM_ADDR_BITS  = 17;
	localparam int MBC2_CELL_BITS = 9;

	localparam int ADDR_BITS    = 16;
	localparam int BYTE_BITS    = 8;
	localparam int S_DATA_BITS  = 24;
	localparam int M_DATA_BITS  = 48;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DAT_BITS = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_KIND     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROM_SIZE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RAM_SIZE = 2'd2;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_MBC1 = 3'd1,
		KIND_MBC2 = 3'd2,
		KIND_MBC3 = 3'd3,
		KIND_MBC5 = 3'd4
	} cbc_kind_t;

	typedef struct packed {
		logic                     ram_on;
		logic [7:0]               bank_low;
		logic                     bank_ninth;
		logic [3:0]               upper;
		logic                     mode;
		logic [ROM_BANK_BITS-1:0] rom_low;
		logic [ROM_BANK_BITS-1:0] rom_high;
		logic [1:0]               ram_sel;
	} cbc_state_t;

	localparam cbc_state_t STATE_RESET = '{
		ram_on:     1'b0,
		bank_low:   8'd1,
		bank_ninth: 1'b0,
		upper:      4'd0,
		mode:       1'b0,
		rom_low:    '0,
		rom_high:   ROM_BANK_BITS'(1),
		ram_sel:    2'd0
	};

	typedef struct packed {
		logic                     strobe;
		logic [RAM_ADDR_BITS-1:0] waddr;
		logic [BYTE_BITS-1:0]     wdata;
	} cbc_wr_t;

	// Bank mask 2^(code+1)-1, saturating at the full bank width
	function automatic logic [ROM_BANK_BITS-1:0] bank_mask(input logic [3:0] code);
		logic [4:0] sh;
		sh = {1'b0, code} + 5'd1;
		if (sh >= 5'(ROM_BANK_BITS))
			return '1;
		return ~({ROM_BANK_BITS{1'b1}} << sh);
	endfunction

endpackage

// ===== hw/rtl/cartridge_bank_controller.sv =====
// Top level of the cartridge bank controller: input stage, decode, result stage.
`timescale 1ns / 1ps

// Channel   | Direction | Payload (low bits first)
// s_*       | in        | bus_address[15:0], write_byte[23:16]
// m_*       | out       | low_window_bank, high_window_bank, ram_window_bank, ram_enabled,
//           |           | ram_write_strobe, ram_write_address, ram_write_data, zero pad
// cfg_*     | in        | write-only: 0 controller_kind, 1 rom_size_code, 2 ram_size_code
//
// One write is taken per cycle while m_* is not stalled; its result passes the input
// register, then the result register, before it shows on m_* and can transfer out.
// Reset clears the bank state to its power-on mapping and all config to zero.
// A stall on m_* holds the result and, once the input register is full,
// drops s_tready; the bank state advances only when a write leaves the input stage.
module cartridge_bank_controller
	import cbc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_DATA_BITS-1:0]  s_tdata,   // bus_address[15:0], write_byte[23:16]
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_DATA_BITS-1:0]  m_tdata,   // low_window_bank[8:0], high_window_bank[17:9],
	                                           // ram_window_bank[19:18], ram_enabled[20],
	                                           // ram_write_strobe[21], ram_write_address[38:22],
	                                           // ram_write_data[46:39], zero[47]
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DAT_BITS-1:0] cfg_data
);

	// configuration registers
	logic [2:0] kind_q;
	logic [3:0] rom_code_q;
	logic [2:0] ram_code_q;

	// bank state
	cbc_state_t state_q;
	cbc_state_t state_nxt;
	cbc_wr_t    wr_nxt;

	// input stage
	logic                 valid_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [BYTE_BITS-1:0] byte_s1;

	// result stage
	logic                   valid_s2;
	logic [M_DATA_BITS-1:0] data_s2;

	logic advance;

	// The result register takes a new write when empty or being drained.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= '0;
			rom_code_q <= '0;
			ram_code_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KIND:     kind_q     <= cfg_data[2:0];
				CFG_ROM_SIZE: rom_code_q <= cfg_data;
				CFG_RAM_SIZE: ram_code_q <= cfg_data[2:0];
				default:      kind_q     <= kind_q;
			endcase
		end
	end

	// Hold the write in the input register until the result stage can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			addr_s1 <= s_tdata[ADDR_BITS-1:0];
			byte_s1 <= s_tdata[ADDR_BITS +: BYTE_BITS];
		end
	end

	cbc_decode u_decode (
		.cfg_kind (kind_q),
		.rom_code (rom_code_q),
		.ram_code (ram_code_q),
		.cur      (state_q),
		.addr     (addr_s1),
		.wbyte    (byte_s1),
		.nxt      (state_nxt),
		.wr       (wr_nxt)
	);

	// Commit the bank state only when the write moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {1'b0, wr_nxt.wdata, wr_nxt.waddr, wr_nxt.strobe, state_nxt.ram_on,
				state_nxt.ram_sel, state_nxt.rom_high, state_nxt.rom_low};
		end
	end

endmodule

// ===== hw/rtl/cbc_decode.sv =====
// Write decode and bank recompute for one CPU write.
`timescale 1ns / 1ps

module cbc_decode
	import cbc_pkg::*;
(
	input  logic [2:0]           cfg_kind,
	input  logic [3:0]           rom_code,
	input  logic [2:0]           ram_code,
	input  cbc_state_t           cur,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [BYTE_BITS-1:0] wbyte,
	output cbc_state_t           nxt,
	output cbc_wr_t              wr
);

	cbc_kind_t                kind;
	logic [ROM_BANK_BITS-1:0] mask;
	logic                     in_ram;
	logic                     in_video;
	logic                     ram_bank_ok;

	assign kind        = (cfg_kind > 3'(KIND_MBC5)) ? KIND_MBC5 : cbc_kind_t'(cfg_kind);
	assign mask        = bank_mask(rom_code);
	assign in_ram      = (addr[15:13] == 3'b101);
	assign in_video    = (addr[15:13] == 3'b100);
	assign ram_bank_ok = (ram_code > 3'd2);

	always_comb begin
		logic [6:0] b;
		b   = '0;
		nxt = cur;
		wr  = '0;
		if (in_ram) begin
			if (cur.ram_on) begin
				wr.strobe = 1'b1;
				if (kind == KIND_MBC2) begin
					wr.waddr = RAM_ADDR_BITS'(addr[MBC2_CELL_BITS-1:0]);
					wr.wdata = {4'd0, wbyte[3:0]};
				end else begin
					wr.waddr = RAM_ADDR_BITS'({cur.ram_sel, addr[RAM_OFS_BITS-1:0]});
					wr.wdata = wbyte;
				end
			end
		end else if (in_video) begin
			nxt = cur;
		end else if (kind == KIND_MBC2) begin
			if (addr[15:14] == 2'b00) begin
				if (!addr[8]) begin
					nxt.ram_on = (wbyte[3:0] == RAM_ENABLE_KEY);
				end else begin
					b = {3'd0, wbyte[3:0]};
					if (b == 7'd0)
						b = 7'd1;
					nxt.rom_high = ROM_BANK_BITS'(b) & mask;
				end
			end
		end else if (kind != KIND_NONE) begin
			// register writes
			if (addr[15:13] == 3'b000) begin
				nxt.ram_on = (wbyte[3:0] == RAM_ENABLE_KEY);
			end else if (addr[15:14] == 2'b00) begin
				case (kind)
					KIND_MBC1: nxt.bank_low = {3'd0, wbyte[4:0]};
					KIND_MBC3: nxt.bank_low = {1'b0, wbyte[6:0]};
					default: begin
						if (!addr[12])
							nxt.bank_low = wbyte;
						else
							nxt.bank_ninth = wbyte[0];
					end
				endcase
			end else if (addr[15:13] == 3'b010) begin
				nxt.upper = (kind == KIND_MBC1) ? {2'd0, wbyte[1:0]} : wbyte[3:0];
			end else if (addr[15:13] == 3'b011) begin
				if (kind == KIND_MBC1)
					nxt.mode = wbyte[0];
			end
			// recompute windows from the updated registers
			case (kind)
				KIND_MBC1: begin
					b = {2'd0, nxt.bank_low[4:0]};
					if (b == 7'd0)
						b = 7'd1;
					nxt.rom_high = ROM_BANK_BITS'({nxt.upper[1:0], b[4:0]}) & mask;
					nxt.rom_low  = nxt.mode ?
						(ROM_BANK_BITS'({nxt.upper[1:0], 5'd0}) & mask) : '0;
					nxt.ram_sel  = (ram_bank_ok && nxt.mode) ? nxt.upper[1:0] : 2'd0;
				end
				KIND_MBC3: begin
					b = nxt.bank_low[6:0];
					if (b == 7'd0)
						b = 7'd1;
					nxt.rom_low  = '0;
					nxt.rom_high = ROM_BANK_BITS'(b) & mask;
					nxt.ram_sel  = ram_bank_ok ? nxt.upper[1:0] : 2'd0;
				end
				default: begin
					nxt.rom_low  = '0;
					nxt.rom_high = ROM_BANK_BITS'({nxt.bank_ninth, nxt.bank_low}) & mask;
					nxt.ram_sel  = ram_bank_ok ? nxt.upper[1:0] : 2'd0;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/cbc_checker.sv =====
// Port-level checks on the cartridge bank controller, bound to the top level.
`timescale 1ns / 1ps

module cbc_checker
	import cbc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [M_DATA_BITS-1:0]  m_tdata
);

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A RAM store needs the RAM enable.
	a_strobe_en: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[21] |-> m_tdata[20])
		else $error("RAM store while RAM disabled");

	// Without a store the address and data are zero.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[21] |-> m_tdata[46:22] == 25'd0)
		else $error("RAM address or data set without a store");

	// Four RAM banks of 8 KiB never reach the top address bits.
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[38:37] == 2'd0 && !m_tdata[47])
		else $error("RAM address or pad out of range");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (.*);

// ===== tb/cbc_bank_checker.sv =====
// Shadow model and result scoreboard for the cartridge bank controller.
`timescale 1ns / 1ps

module cbc_bank_checker
	import cbc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [S_DATA_BITS-1:0]  s_tdata,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [M_DATA_BITS-1:0]  m_tdata,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DAT_BITS-1:0] cfg_data,
	output int                      mismatches,
	output int                      outstanding
);

	localparam logic [2:0] VIDEO_WINDOW = 3'b100;
	localparam logic [2:0] RAM_WINDOW   = 3'b101;

	// Declared from the top bit down so low_bank lands at bit 0 of m_tdata
	typedef struct packed {
		logic [BYTE_BITS-1:0]     wdata;
		logic [RAM_ADDR_BITS-1:0] waddr;
		logic                     strobe;
		logic                     ram_en;
		logic [1:0]               ram_bank;
		logic [ROM_BANK_BITS-1:0] high_bank;
		logic [ROM_BANK_BITS-1:0] low_bank;
	} bank_view_t;

	logic [2:0] kind_raw;
	logic [3:0] rom_code;
	logic [2:0] ram_code;

	logic                     ram_on_q;
	logic [7:0]               low_sel;
	logic                     ninth;
	logic [3:0]               upper;
	logic                     mode_q;
	logic [ROM_BANK_BITS-1:0] win_low;
	logic [ROM_BANK_BITS-1:0] win_high;
	logic [1:0]               ram_sel;

	bank_view_t bank_view_q[$];

	function automatic logic [ROM_BANK_BITS-1:0] rom_mask(input logic [3:0] code);
		if (int'(code) + 1 >= ROM_BANK_BITS)
			return '1;
		return ROM_BANK_BITS'((1 << (int'(code) + 1)) - 1);
	endfunction

	task automatic refresh_windows(input cbc_kind_t k);
		logic [ROM_BANK_BITS-1:0] m;
		logic [ROM_BANK_BITS-1:0] b;
		logic [ROM_BANK_BITS-1:0] hi2;
		m   = rom_mask(rom_code);
		hi2 = ROM_BANK_BITS'({upper[1:0], 5'd0});
		case (k)
		KIND_MBC1: begin
			b = ROM_BANK_BITS'(low_sel[4:0]);
			if (b == '0)
				b = ROM_BANK_BITS'(1);
			win_high = (hi2 | b) & m;
			win_low  = mode_q ? (hi2 & m) : '0;
			ram_sel  = (ram_code > 3'd2 && mode_q) ? upper[1:0] : 2'd0;
		end
		KIND_MBC3: begin
			b = ROM_BANK_BITS'(low_sel[6:0]);
			if (b == '0)
				b = ROM_BANK_BITS'(1);
			win_high = b & m;
			win_low  = '0;
			ram_sel  = (ram_code > 3'd2) ? upper[1:0] : 2'd0;
		end
		default: begin
			win_high = {ninth, low_sel} & m;
			win_low  = '0;
			ram_sel  = (ram_code > 3'd2) ? upper[1:0] : 2'd0;
		end
		endcase
	endtask

	task automatic predict_bus_write(input logic [15:0] a, input logic [7:0] d,
			output bank_view_t r);
		cbc_kind_t  k;
		logic [3:0] nib;
		k = (kind_raw > 3'(KIND_MBC5)) ? KIND_MBC5 : cbc_kind_t'(kind_raw);
		r = '0;
		if (a[15:13] == RAM_WINDOW) begin
			if (ram_on_q) begin
				r.strobe = 1'b1;
				if (k == KIND_MBC2) begin
					r.waddr = RAM_ADDR_BITS'(a[8:0]);
					r.wdata = BYTE_BITS'(d[3:0]);
				end else begin
					r.waddr = RAM_ADDR_BITS'({ram_sel, a[12:0]});
					r.wdata = d;
				end
			end
		end else if (a[15:13] == VIDEO_WINDOW) begin
			// video range: no effect for any kind
		end else if (k == KIND_MBC2) begin
			if (a[15:14] == 2'b00) begin
				if (!a[8]) begin
					ram_on_q = (d[3:0] == RAM_ENABLE_KEY);
				end else begin
					nib = d[3:0];
					if (nib == 4'd0)
						nib = 4'd1;
					win_high = ROM_BANK_BITS'(nib) & rom_mask(rom_code);
				end
			end
		end else if (k != KIND_NONE) begin
			case (a[15:13])
			3'd0: ram_on_q = (d[3:0] == RAM_ENABLE_KEY);
			3'd1: begin
				if (k == KIND_MBC1)
					low_sel = {3'd0, d[4:0]};
				else if (k == KIND_MBC3)
					low_sel = {1'b0, d[6:0]};
				else if (!a[12])
					low_sel = d;
				else
					ninth = d[0];
			end
			3'd2: upper = (k == KIND_MBC1) ? {2'd0, d[1:0]} : d[3:0];
			3'd3: begin
				if (k == KIND_MBC1)
					mode_q = d[0];
			end
			default: ;
			endcase
			refresh_windows(k);
		end
		r.low_bank  = win_low;
		r.high_bank = win_high;
		r.ram_bank  = ram_sel;
		r.ram_en    = ram_on_q;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bank_view_t want;
		bank_view_t got;
		if (!arst_n) begin
			kind_raw    = 3'(KIND_NONE);
			rom_code    = 4'd0;
			ram_code    = 3'd0;
			ram_on_q    = STATE_RESET.ram_on;
			low_sel     = STATE_RESET.bank_low;
			ninth       = STATE_RESET.bank_ninth;
			upper       = STATE_RESET.upper;
			mode_q      = STATE_RESET.mode;
			win_low     = STATE_RESET.rom_low;
			win_high    = STATE_RESET.rom_high;
			ram_sel     = STATE_RESET.ram_sel;
			mismatches  = 0;
			bank_view_q.delete();
			outstanding <= 0;
		end else begin
			// retire before predicting so a result never meets its own write
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(bank_view_t)-1:0];
				if (bank_view_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					mismatches++;
				end else begin
					want = bank_view_q.pop_front();
					check_field("low_window_bank", 32'(want.low_bank), 32'(got.low_bank));
					check_field("high_window_bank", 32'(want.high_bank), 32'(got.high_bank));
					check_field("ram_window_bank", 32'(want.ram_bank), 32'(got.ram_bank));
					check_field("ram_enabled", 32'(want.ram_en), 32'(got.ram_en));
					check_field("ram_write_strobe", 32'(want.strobe), 32'(got.strobe));
					check_field("ram_write_address", 32'(want.waddr), 32'(got.waddr));
					check_field("ram_write_data", 32'(want.wdata), 32'(got.wdata));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_bus_write(s_tdata[15:0], s_tdata[23:16], want);
				bank_view_q.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_KIND:     kind_raw = cfg_data[2:0];
				CFG_ROM_SIZE: rom_code = cfg_data;
				CFG_RAM_SIZE: ram_code = cfg_data[2:0];
				default: ;
				endcase
			end
			outstanding <= bank_view_q.size();
		end
	end

endmodule

// ===== tb/cartridge_bank_controller_tb.sv =====
// Top of the cartridge bank controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module cartridge_bank_controller_tb;
	import cbc_pkg::*;

	// Cap on the whole run, set well above the worst case with both sides stalling.
	localparam int CYCLE_LIMIT  = 200000;
	// Result passes the input register, then the result register; leave a margin.
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASES       = 16;
	localparam int PHASE_WRITES = 110;

	localparam logic [2:0] KIND_ALIAS_TOP = 3'd7;   // highest unknown kind, behaves as MBC5
	localparam logic [3:0] ROM_CODE_MAX   = 4'd15;
	localparam logic [2:0] RAM_CODE_MAX   = 3'd7;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [S_DATA_BITS-1:0]  s_tdata   = '0;   // bus_address[15:0], write_byte[23:16]
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [M_DATA_BITS-1:0]  m_tdata;          // low_window_bank, high_window_bank,
	                                           // ram_window_bank, ram_enabled, ram_write_strobe,
	                                           // ram_write_address, ram_write_data, pad
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = CFG_KIND;
	logic [CFG_DAT_BITS-1:0] cfg_data  = '0;

	int mismatches;
	int outstanding;
	int cycles   = 0;
	bit src_lazy = 1'b0;
	bit snk_lazy = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cartridge_bank_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cbc_bank_checker bank_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offer one bus write; hold valid straight into the next write when no gap is drawn,
	// so valid is never dropped and raised in the same step.
	task automatic send_bus_write(input logic [15:0] a, input logic [7:0] d);
		int gap;
		gap = src_lazy ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {d, a};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid, wait for every expected result, then let the pipeline run dry.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges; only call while idle.
	task automatic load_config(input logic [2:0] kind, input logic [3:0] rom,
			input logic [2:0] ram);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KIND;
		cfg_data  <= {1'b0, kind};
		@(posedge clk);
		cfg_index <= CFG_ROM_SIZE;
		cfg_data  <= rom;
		@(posedge clk);
		cfg_index <= CFG_RAM_SIZE;
		cfg_data  <= {1'b0, ram};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Draw a write by region. RAM enable writes mostly carry the key so RAM stays
	// open long enough for strobes; the RAM window gets the biggest share.
	task automatic pick_bus_write(output logic [15:0] a, output logic [7:0] d);
		int roll;
		roll = $urandom_range(0, 99);
		d    = 8'($urandom);
		if (roll < 15) begin
			a = 16'($urandom_range(16'h0000, 16'h1FFF));
			if ($urandom_range(0, 3) != 0)
				d[3:0] = RAM_ENABLE_KEY;
		end else if (roll < 35) begin
			a = 16'($urandom_range(16'h2000, 16'h3FFF));
		end else if (roll < 45) begin
			a = 16'($urandom_range(16'h4000, 16'h5FFF));
		end else if (roll < 52) begin
			a = 16'($urandom_range(16'h6000, 16'h7FFF));
		end else if (roll < 57) begin
			a = 16'($urandom_range(16'h8000, 16'h9FFF));
		end else if (roll < 90) begin
			a = 16'($urandom_range(16'hA000, 16'hBFFF));
		end else begin
			a = 16'($urandom_range(16'hC000, 16'hFFFF));
		end
	endtask

	// Sink: draw a stall before every result, keep ready high when none is drawn.
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = snk_lazy ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cartridge_bank_controller_tb failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] a;
		logic [7:0]  d;
		logic [2:0]  kind;
		logic [3:0]  rom;
		logic [2:0]  ram;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_lazy = 1'($urandom_range(0, 1));
		snk_lazy = 1'($urandom_range(0, 1));

		// MBC1 with saturating ROM mask and RAM banking allowed
		load_config(3'(KIND_MBC1), ROM_CODE_MAX, 3'd3);
		send_bus_write(16'h0000, 8'h0A);   // open RAM
		send_bus_write(16'h2000, 8'h00);   // bank 0 reads as 1
		send_bus_write(16'h3FFF, 8'hFF);
		send_bus_write(16'h4000, 8'h03);   // upper bits
		send_bus_write(16'h6000, 8'h01);   // mode 1: low window and RAM bank follow upper
		send_bus_write(16'hA000, 8'h5A);
		send_bus_write(16'hBFFF, 8'hFF);
		send_bus_write(16'h8000, 8'hFF);   // video range, no effect
		send_bus_write(16'h9FFF, 8'h00);
		send_bus_write(16'hFFFF, 8'hFF);   // recompute only
		send_bus_write(16'h1FFF, 8'h00);   // close RAM
		send_bus_write(16'hB123, 8'h33);   // no strobe while closed
		settle();

		// MBC2: nibble RAM, control by address bit 8, upper writes ignored
		load_config(3'(KIND_MBC2), 4'd2, 3'd0);
		send_bus_write(16'h0000, 8'h0A);
		send_bus_write(16'h0100, 8'h00);   // bank 0 reads as 1
		send_bus_write(16'h3FFF, 8'hFF);   // bank 15, masked by small ROM
		send_bus_write(16'h4000, 8'h07);   // ignored
		send_bus_write(16'hA3FF, 8'hA5);   // wraps into 512 cells, low nibble only
		send_bus_write(16'hC000, 8'h0A);   // ignored
		settle();

		// unknown kind acts as MBC5: ninth bank bit and full low byte
		load_config(KIND_ALIAS_TOP, 4'd8, 3'd5);
		send_bus_write(16'h3000, 8'hFF);
		send_bus_write(16'h2FFF, 8'hFF);
		send_bus_write(16'h5FFF, 8'hFF);
		send_bus_write(16'h0000, 8'hEA);
		send_bus_write(16'hBFFF, 8'h81);
		settle();

		// MBC3: zero bank maps to one, latch range only recomputes
		load_config(3'(KIND_MBC3), 4'd6, RAM_CODE_MAX);
		send_bus_write(16'h2000, 8'h80);
		send_bus_write(16'h7FFF, 8'h01);
		settle();

		// Random phases: every kind value, ROM and RAM codes at their ends and between
		for (int p = 0; p < PHASES; p++) begin
			kind = 3'(p % 8);
			rom  = (p % 5 == 0) ? 4'd0 :
			       (p % 5 == 1) ? ROM_CODE_MAX : 4'($urandom_range(0, 9));
			ram  = (p % 3 == 0) ? 3'd0 :
			       (p % 3 == 1) ? RAM_CODE_MAX : 3'($urandom_range(0, 7));
			src_lazy = ($urandom_range(0, 3) != 0);
			snk_lazy = ($urandom_range(0, 3) != 0);
			load_config(kind, rom, ram);
			for (int i = 0; i < PHASE_WRITES; i++) begin
				pick_bus_write(a, d);
				send_bus_write(a, d);
			end
			settle();
		end

		if (mismatches == 0)
			$display("cartridge_bank_controller_tb passed");
		else
			$display("cartridge_bank_controller_tb failed");
		$finish;
	end

endmodule
